/* src/rrva_pkg.sv */
// shared types, constants and note tables of the round-robin voice allocator
package rrva_pkg;

  localparam int unsigned ScanBits  = 61;
  localparam int unsigned ExtBits   = 64;
  localparam int unsigned KeyBits   = 6;
  localparam int unsigned VoiceBits = 3;
  localparam int unsigned FreqBits  = 11;
  localparam int unsigned PwmBits   = 11;

  typedef struct packed {
    logic                 rel_any;
    logic                 prs_any;
    logic                 hit;
    logic                 hold_valid;
    logic                 out_free;
  } sts_t;

  typedef struct packed {
    logic                 load;
    logic                 rel_step;
    logic                 prs_step;
    logic                 flush;
  } cmd_t;

  typedef struct packed {
    logic [VoiceBits-1:0] voice;
    logic [KeyBits-1:0]   note;
    logic                 gate_on;
    logic [FreqBits-1:0]  freq_hz;
    logic [PwmBits-1:0]   pwm_level;
  } res_t;

  // keys past the top of the table use the top entry
  function automatic logic [FreqBits-1:0] freq_rom(input logic [KeyBits-1:0] idx);
    logic [FreqBits-1:0] f;
    case (idx)
      6'd0:  f = 11'd32;   6'd1:  f = 11'd34;   6'd2:  f = 11'd36;   6'd3:  f = 11'd38;
      6'd4:  f = 11'd41;   6'd5:  f = 11'd43;   6'd6:  f = 11'd46;   6'd7:  f = 11'd48;
      6'd8:  f = 11'd51;   6'd9:  f = 11'd55;   6'd10: f = 11'd58;   6'd11: f = 11'd61;
      6'd12: f = 11'd65;   6'd13: f = 11'd69;   6'd14: f = 11'd73;   6'd15: f = 11'd77;
      6'd16: f = 11'd82;   6'd17: f = 11'd87;   6'd18: f = 11'd92;   6'd19: f = 11'd97;
      6'd20: f = 11'd103;  6'd21: f = 11'd110;  6'd22: f = 11'd116;  6'd23: f = 11'd123;
      6'd24: f = 11'd130;  6'd25: f = 11'd138;  6'd26: f = 11'd146;  6'd27: f = 11'd155;
      6'd28: f = 11'd164;  6'd29: f = 11'd174;  6'd30: f = 11'd184;  6'd31: f = 11'd195;
      6'd32: f = 11'd207;  6'd33: f = 11'd220;  6'd34: f = 11'd233;  6'd35: f = 11'd246;
      6'd36: f = 11'd261;  6'd37: f = 11'd277;  6'd38: f = 11'd293;  6'd39: f = 11'd311;
      6'd40: f = 11'd329;  6'd41: f = 11'd349;  6'd42: f = 11'd369;  6'd43: f = 11'd391;
      6'd44: f = 11'd415;  6'd45: f = 11'd440;  6'd46: f = 11'd466;  6'd47: f = 11'd493;
      6'd48: f = 11'd523;  6'd49: f = 11'd554;  6'd50: f = 11'd587;  6'd51: f = 11'd622;
      6'd52: f = 11'd659;  6'd53: f = 11'd698;  6'd54: f = 11'd739;  6'd55: f = 11'd783;
      6'd56: f = 11'd830;  6'd57: f = 11'd880;  6'd58: f = 11'd932;  6'd59: f = 11'd987;
      default: f = 11'd1046;
    endcase
    return f;
  endfunction

  function automatic logic [PwmBits-1:0] pwm_rom(input logic [KeyBits-1:0] idx);
    logic [PwmBits-1:0] p;
    case (idx)
      6'd0:  p = 11'd9;    6'd1:  p = 11'd10;   6'd2:  p = 11'd11;   6'd3:  p = 11'd11;
      6'd4:  p = 11'd12;   6'd5:  p = 11'd13;   6'd6:  p = 11'd14;   6'd7:  p = 11'd15;
      6'd8:  p = 11'd15;   6'd9:  p = 11'd16;   6'd10: p = 11'd17;   6'd11: p = 11'd19;
      6'd12: p = 11'd20;   6'd13: p = 11'd21;   6'd14: p = 11'd22;   6'd15: p = 11'd24;
      6'd16: p = 11'd25;   6'd17: p = 11'd27;   6'd18: p = 11'd28;   6'd19: p = 11'd30;
      6'd20: p = 11'd32;   6'd21: p = 11'd34;   6'd22: p = 11'd36;   6'd23: p = 11'd38;
      6'd24: p = 11'd40;   6'd25: p = 11'd43;   6'd26: p = 11'd45;   6'd27: p = 11'd48;
      6'd28: p = 11'd51;   6'd29: p = 11'd54;   6'd30: p = 11'd57;   6'd31: p = 11'd61;
      6'd32: p = 11'd64;   6'd33: p = 11'd68;   6'd34: p = 11'd72;   6'd35: p = 11'd77;
      6'd36: p = 11'd81;   6'd37: p = 11'd86;   6'd38: p = 11'd91;   6'd39: p = 11'd97;
      6'd40: p = 11'd102;  6'd41: p = 11'd109;  6'd42: p = 11'd115;  6'd43: p = 11'd122;
      6'd44: p = 11'd129;  6'd45: p = 11'd137;  6'd46: p = 11'd145;  6'd47: p = 11'd154;
      6'd48: p = 11'd163;  6'd49: p = 11'd173;  6'd50: p = 11'd183;  6'd51: p = 11'd194;
      6'd52: p = 11'd205;  6'd53: p = 11'd218;  6'd54: p = 11'd231;  6'd55: p = 11'd244;
      6'd56: p = 11'd259;  6'd57: p = 11'd274;  6'd58: p = 11'd291;  6'd59: p = 11'd308;
      default: p = 11'd327;
    endcase
    return p;
  endfunction

endpackage

/* src/rrva_ctrl.sv */
// controller state machine sequencing release and press events of one scan
module rrva_ctrl import rrva_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic idle_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRelease,
    StPress,
    StFlush
  } state_e;

  state_e state_q, state_d;
  logic   can_step;

  assign can_step = !sts_i.hold_valid || sts_i.out_free;
  assign idle_o   = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRelease;
        end
      end
      StRelease: begin
        if (!sts_i.rel_any) begin
          state_d = StPress;
        end else if (can_step || !sts_i.hit) begin
          cmd_o.rel_step = 1'b1;
        end
      end
      StPress: begin
        if (!sts_i.prs_any) begin
          state_d = StFlush;
        end else if (can_step) begin
          cmd_o.prs_step = 1'b1;
        end
      end
      StFlush: begin
        if (!sts_i.hold_valid) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/rrva_datapath.sv */
// datapath: scan masks, voice table, round-robin pointer and result registers
module rrva_datapath import rrva_pkg::*; #(
  parameter int unsigned VOICE_COUNT = 6,
  parameter int unsigned KEY_COUNT   = 61
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ScanBits-1:0]  key_bitmap_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output res_t                 res_o,
  output logic                 last_o
);

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VW-1:0] VoiceTop = VW'(VOICE_COUNT - 1);

  logic [KEY_COUNT-1:0]   prev_q, rel_q, prs_q;
  logic [KEY_COUNT-1:0]   cur, rel_oh, prs_oh;
  logic [ExtBits-1:0]     ext;
  logic [KeyBits-1:0]     rel_key, prs_key;
  logic [VOICE_COUNT-1:0] busy_q, match, match_oh;
  logic [KeyBits-1:0]     note_q [VOICE_COUNT];
  logic [VW-1:0]          next_q, hit_v;
  logic [VW+VoiceBits-1:0] hit_ext, prs_ext;
  logic                   hit;
  logic                   new_valid, out_taken;
  res_t                   new_res, hold_q, out_q;
  logic                   hold_valid_q, out_valid_q, out_last_q;

  assign ext = ExtBits'(key_bitmap_i);
  assign cur = ext[KEY_COUNT-1:0];

  // lowest pending key of each mask
  assign rel_oh = rel_q & (~rel_q + 1'b1);
  assign prs_oh = prs_q & (~prs_q + 1'b1);

  always_comb begin
    rel_key = '0;
    prs_key = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      rel_key |= rel_oh[i] ? KeyBits'(i) : '0;
      prs_key |= prs_oh[i] ? KeyBits'(i) : '0;
    end
  end

  // lowest busy voice holding the released note
  always_comb begin
    for (int v = 0; v < VOICE_COUNT; v++) begin
      match[v] = busy_q[v] && (note_q[v] == rel_key);
    end
  end

  assign match_oh = match & (~match + 1'b1);
  assign hit      = |match;

  always_comb begin
    hit_v = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      hit_v |= match_oh[v] ? VW'(v) : '0;
    end
  end

  assign hit_ext = (VW+VoiceBits)'(hit_v);
  assign prs_ext = (VW+VoiceBits)'(next_q);

  always_comb begin
    new_res = '0;
    if (cmd_i.prs_step) begin
      new_res.voice     = prs_ext[VoiceBits-1:0];
      new_res.note      = prs_key;
      new_res.gate_on   = 1'b1;
      new_res.freq_hz   = freq_rom(prs_key);
      new_res.pwm_level = pwm_rom(prs_key);
    end else begin
      new_res.voice = hit_ext[VoiceBits-1:0];
      new_res.note  = rel_key;
    end
  end

  assign new_valid = (cmd_i.rel_step && hit) || cmd_i.prs_step;
  assign out_taken = out_valid_q && !out_stall_i;

  // scan masks, voice table and pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rel_q  <= '0;
      prs_q  <= '0;
      busy_q <= '0;
      next_q <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        note_q[v] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        rel_q  <= ~cur & prev_q;
        prs_q  <= cur & ~prev_q;
        prev_q <= cur;
      end
      if (cmd_i.rel_step) begin
        rel_q <= rel_q & ~rel_oh;
        if (hit) begin
          busy_q[hit_v] <= 1'b0;
          note_q[hit_v] <= '0;
        end
      end
      if (cmd_i.prs_step) begin
        prs_q          <= prs_q & ~prs_oh;
        busy_q[next_q] <= 1'b1;
        note_q[next_q] <= prs_key;
        next_q         <= (next_q == VoiceTop) ? '0 : next_q + 1'b1;
      end
    end
  end

  // one result is held back until it is known whether another follows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (new_valid) begin
        hold_valid_q <= 1'b1;
        if (hold_valid_q) begin
          out_valid_q <= 1'b1;
        end else if (out_taken) begin
          out_valid_q <= 1'b0;
        end
      end else if (cmd_i.flush) begin
        hold_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_valid) begin
      hold_q <= new_res;
      if (hold_valid_q) begin
        out_q      <= hold_q;
        out_last_q <= 1'b0;
      end
    end else if (cmd_i.flush) begin
      out_q      <= hold_q;
      out_last_q <= 1'b1;
    end
  end

  assign sts_o.rel_any    = |rel_q;
  assign sts_o.prs_any    = |prs_q;
  assign sts_o.hit        = hit;
  assign sts_o.hold_valid = hold_valid_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign last_o      = out_last_q;

endmodule

/* src/round_robin_voice_allocator.sv */
// top level of the round-robin polyphonic voice allocator
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i, in_stall_o  key_bitmap_i
//   out      output     out_valid_o, out_stall_i voice_o note_o gate_on_o freq_hz_o
//                                               pwm_level_o last_o
//
// one scan is loaded, then each released key and each pressed key is stepped in turn,
// the release and press phases are closed and the final result is flushed; a new scan
// is stalled until the previous one is fully walked
// the priority encoder over the pending key masks handles one key event per cycle unless
// held: a stalled output holds the event walk only when the held result cannot move on
// reset clears the previous scan, voice table and pointer at once
module round_robin_voice_allocator import rrva_pkg::*; #(
  parameter int unsigned VOICE_COUNT = 6,
  parameter int unsigned KEY_COUNT   = 61
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ScanBits-1:0]  key_bitmap_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VoiceBits-1:0] voice_o,
  output logic [KeyBits-1:0]   note_o,
  output logic                 gate_on_o,
  output logic [FreqBits-1:0]  freq_hz_o,
  output logic [PwmBits-1:0]   pwm_level_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic idle;

  rrva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  rrva_datapath #(
    .VOICE_COUNT (VOICE_COUNT),
    .KEY_COUNT   (KEY_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_bitmap_i (key_bitmap_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .res_o        (res),
    .last_o       (last_o)
  );

  assign in_stall_o  = !idle;
  assign voice_o     = res.voice;
  assign note_o      = res.note;
  assign gate_on_o   = res.gate_on;
  assign freq_hz_o   = res.freq_hz;
  assign pwm_level_o = res.pwm_level;

  // a new scan only starts once the previous one is fully walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !sts.hold_valid && !sts.rel_any && !sts.prs_any)
    else $error("scan accepted while events pending");

  // an opened gate always carries a nonzero frequency and level from the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gate_on_o |-> freq_hz_o != '0 && pwm_level_o != '0)
    else $error("gate on without frequency");

  // a freed voice carries no frequency or level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gate_on_o |-> freq_hz_o == '0 && pwm_level_o == '0)
    else $error("release with nonzero frequency");

endmodule

/* tb/round_robin_voice_allocator_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the round-robin voice allocator with driver, monitor and predictor
module round_robin_voice_allocator_test;
  import rrva_pkg::*;

  localparam int unsigned VoiceCount = 6;
  localparam int unsigned KeyCount   = 61;
  localparam int unsigned RandScans  = 270;
  localparam int unsigned CalmTail   = 50;
  localparam int unsigned DrainCycles = 100;
  localparam logic GateOpen = 1'b1;
  localparam logic GateFree = 1'b0;
  localparam logic [ScanBits-1:0] AllKeys = {ScanBits{1'b1}};

  typedef struct packed {
    logic [VoiceBits-1:0] voice;
    logic [KeyBits-1:0]   note;
    logic                 gate_on;
    logic [FreqBits-1:0]  freq_hz;
    logic [PwmBits-1:0]   pwm_level;
    logic                 last;
  } voice_event_t;

  typedef struct packed {
    logic [ScanBits-1:0] bits;
    logic [4:0]          gap;
    logic [1:0]          rate;
    logic                drain;
  } scan_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [ScanBits-1:0]  key_bitmap_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [VoiceBits-1:0] voice_o;
  logic [KeyBits-1:0]   note_o;
  logic                 gate_on_o;
  logic [FreqBits-1:0]  freq_hz_o;
  logic [PwmBits-1:0]   pwm_level_o;
  logic                 last_o;

  logic [FreqBits-1:0] key_freq_hz [0:60] = '{
    32, 34, 36, 38, 41, 43, 46, 48, 51, 55, 58, 61,
    65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
    130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
    261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
    523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
    1046};
  logic [PwmBits-1:0] note_pwm [0:60] = '{
    9, 10, 11, 11, 12, 13, 14, 15, 15, 16, 17, 19,
    20, 21, 22, 24, 25, 27, 28, 30, 32, 34, 36, 38,
    40, 43, 45, 48, 51, 54, 57, 61, 64, 68, 72, 77,
    81, 86, 91, 97, 102, 109, 115, 122, 129, 137, 145, 154,
    163, 173, 183, 194, 205, 218, 231, 244, 259, 274, 291, 308,
    327};

  logic [ScanBits-1:0] held_keys = '0;
  logic [KeyBits-1:0]  voice_note [VoiceCount];
  logic                voice_busy [VoiceCount];
  int unsigned         rr_voice = 0;

  voice_event_t voice_event_q [$];
  scan_item_t   scan_q [$];
  scan_item_t   head;
  bit           have_head = 1'b0;
  int           gap_left = 0;
  logic [1:0]   stall_rate = '0;
  int           stall_left = 0;
  int           errors = 0;

  round_robin_voice_allocator #(
    .VOICE_COUNT(VoiceCount),
    .KEY_COUNT  (KeyCount)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_bitmap_i(key_bitmap_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .voice_o     (voice_o),
    .note_o      (note_o),
    .gate_on_o   (gate_on_o),
    .freq_hz_o   (freq_hz_o),
    .pwm_level_o (pwm_level_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // releases first, then presses, both lowest key first
  task automatic predict_voice_events(input logic [ScanBits-1:0] scan);
    logic [ScanBits-1:0] pressed;
    logic [ScanBits-1:0] released;
    voice_event_t        ev;
    voice_event_t        held;
    bit                  have_held;
    bit                  found;
    int unsigned         v;
    pressed   = scan & ~held_keys;
    released  = ~scan & held_keys;
    have_held = 1'b0;
    held      = '0;
    for (int k = 0; k < KeyCount; k++) begin
      if (released[k]) begin
        found = 1'b0;
        for (int w = 0; w < VoiceCount; w++) begin
          if (!found && voice_busy[w] && voice_note[w] == KeyBits'(k)) begin
            found         = 1'b1;
            voice_busy[w] = 1'b0;
            voice_note[w] = '0;
            ev.voice      = VoiceBits'(w);
            ev.note       = KeyBits'(k);
            ev.gate_on    = GateFree;
            ev.freq_hz    = '0;
            ev.pwm_level  = '0;
            ev.last       = 1'b0;
            if (have_held) voice_event_q.push_back(held);
            held      = ev;
            have_held = 1'b1;
          end
        end
      end
    end
    for (int k = 0; k < KeyCount; k++) begin
      if (pressed[k]) begin
        v             = rr_voice;
        voice_note[v] = KeyBits'(k);
        voice_busy[v] = 1'b1;
        ev.voice      = VoiceBits'(v);
        ev.note       = KeyBits'(k);
        ev.gate_on    = GateOpen;
        ev.freq_hz    = key_freq_hz[k];
        ev.pwm_level  = note_pwm[k];
        ev.last       = 1'b0;
        if (have_held) voice_event_q.push_back(held);
        held      = ev;
        have_held = 1'b1;
        rr_voice  = (v == VoiceCount - 1) ? 0 : v + 1;
      end
    end
    held_keys = scan;
    if (have_held) begin
      held.last = 1'b1;
      voice_event_q.push_back(held);
    end
  endtask

  task automatic add_scan(input logic [ScanBits-1:0] bits, input int rate, input bit drain);
    scan_item_t item;
    item.bits  = bits;
    item.rate  = 2'(rate);
    item.drain = drain;
    item.gap   = '0;
    if (rate == 1 && $urandom_range(0, 5) == 0) item.gap = 5'($urandom_range(1, 17));
    if (rate == 2 && $urandom_range(0, 1) == 0) item.gap = 5'($urandom_range(1, 17));
    scan_q.push_back(item);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_voice_events(key_bitmap_i);
      if (!in_valid_i || !in_stall_o) begin
        if (!have_head && scan_q.size() != 0) begin
          head      = scan_q.pop_front();
          have_head = 1'b1;
          gap_left  = head.gap;
        end
        if (!have_head) begin
          in_valid_i <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (head.drain && voice_event_q.size() != 0) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i   <= 1'b1;
          key_bitmap_i <= head.bits;
          stall_rate   <= head.rate;
          have_head    = 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    voice_event_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (voice_event_q.size() == 0) begin
          $error("result with no transaction pending: voice %0d note %0d gate %0d",
                 voice_o, note_o, gate_on_o);
          errors++;
        end else begin
          want = voice_event_q.pop_front();
          check_field("voice", want.voice, voice_o);
          check_field("note", want.note, note_o);
          check_field("gate_on", want.gate_on, gate_on_o);
          check_field("freq_hz", want.freq_hz, freq_hz_o);
          check_field("pwm_level", want.pwm_level, pwm_level_o);
          check_field("last", want.last, last_o);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if ((stall_rate == 1 && $urandom_range(0, 15) == 0) ||
                   (stall_rate == 2 && $urandom_range(0, 4) == 0)) begin
        stall_left <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [ScanBits-1:0] scan;
    logic [ScanBits-1:0] chord;
    int                  level;
    int                  kind;
    int unsigned         changing;
    for (int w = 0; w < VoiceCount; w++) begin
      voice_note[w] = '0;
      voice_busy[w] = 1'b0;
    end

    // directed scans
    chord = ScanBits'({ScanBits/2{2'b01}});
    add_scan('0, 1, 1'b0);
    add_scan(ScanBits'(1), 1, 1'b0);
    add_scan(ScanBits'(1), 1, 1'b0);
    add_scan('0, 1, 1'b0);
    add_scan(ScanBits'(1) << (KeyCount - 1), 1, 1'b0);
    add_scan(AllKeys, 2, 1'b0);
    add_scan(AllKeys, 2, 1'b1);
    add_scan('0, 2, 1'b0);
    add_scan(chord, 1, 1'b0);
    add_scan(~chord, 1, 1'b0);
    add_scan('0, 0, 1'b1);
    // the voice holding key 5 gets stolen, so its release is silent
    add_scan(ScanBits'(1) << 5, 0, 1'b0);
    add_scan((ScanBits'(1) << 5) | (ScanBits'(63) << 10), 0, 1'b0);
    add_scan(ScanBits'(63) << 10, 0, 1'b0);
    add_scan('0, 1, 1'b0);
    add_scan(AllKeys ^ (ScanBits'(1) << 30), 1, 1'b0);
    add_scan(ScanBits'(1) << 30, 1, 1'b0);
    add_scan('0, 1, 1'b0);

    // random scans, mostly a few keys moving at a time
    scan     = '0;
    changing = 0;
    level    = 1;
    while (changing < RandScans) begin
      if (changing % 25 == 0) level = $urandom_range(0, 2);
      if (changing >= RandScans - CalmTail) level = 0;
      kind  = $urandom_range(0, 19);
      chord = scan;
      if (kind < 14) begin
        repeat ($urandom_range(1, 4)) chord ^= ScanBits'(1) << $urandom_range(0, KeyCount - 1);
      end else if (kind < 16) begin
        chord = ScanBits'({$urandom, $urandom});
      end else if (kind < 18) begin
        chord = '0;
        repeat ($urandom_range(1, 8)) chord |= ScanBits'(1) << $urandom_range(0, KeyCount - 1);
      end else if (kind == 18) begin
        chord = '0;
      end
      if (chord != scan) changing++;
      add_scan(chord, level, level != 0 && $urandom_range(0, 39) == 0);
      scan = chord;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (scan_q.size() != 0 || have_head || in_valid_i) @(posedge clk_i);
    while (voice_event_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
